// ----- rtl/pcapng_pkg.sv -----
// shared types, constants and helpers of the packet block framer
`timescale 1ns / 1ps

package pcapng_pkg;

    localparam logic [31:0] MAX_CAPTURE      = 32'd262144;
    localparam logic [31:0] BLOCK_TYPE_EPB   = 32'h0000_0006;
    localparam logic [31:0] FLAGS_OPT_HEADER = 32'h0004_0002;
    localparam logic [31:0] END_OF_OPTIONS   = 32'h0000_0000;
    localparam logic [31:0] HEADER_BYTES     = 32'd28;
    localparam logic [31:0] TRAILER_BYTES    = 32'd4;
    localparam logic [31:0] FLAGS_OPT_BYTES  = 32'd12;
    localparam logic [29:0] TICKS_RESET      = 30'd1000000;

    localparam int CMD_DEPTH = 4;
    localparam int CMD_PTR_W = $clog2(CMD_DEPTH);

    typedef enum logic {
        OP_START = 1'b0,
        OP_BYTE  = 1'b1
    } t_opcode;

    typedef struct packed {
        logic        opcode;
        logic [7:0]  payload_byte;
        logic [31:0] seconds;
        logic [31:0] fraction;
        logic [18:0] captured_length;
        logic [31:0] original_length;
        logic [31:0] interface_number;
        logic [31:0] packet_flags;
    } t_in_item;

    typedef struct packed {
        logic [31:0] out_word;
        logic        end_of_block;
    } t_out_item;

    // one queued job for the word sequencer
    typedef struct packed {
        logic        is_header;
        logic        trailer;
        logic        has_opt;
        logic [31:0] total;
        logic [31:0] flags;
        logic [31:0] ifnum;
        logic [31:0] sec;
        logic [31:0] frac;
        logic [18:0] caplen;
        logic [31:0] origlen;
        logic [31:0] word;
    } t_cmd;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_TYPE,
        BK_TOTAL,
        BK_IFNUM,
        BK_TS_HI,
        BK_TS_LO,
        BK_CAPLEN,
        BK_ORIGLEN,
        BK_WORD,
        BK_OPT_HDR,
        BK_OPT_VAL,
        BK_OPT_END,
        BK_TRAILER
    } t_back_state;

    typedef struct packed {
        logic push;
        logic pop;
        logic full;
        logic empty;
    } t_q_stat;

    // step that follows the fixed part of a job
    function automatic t_back_state tail_state(input t_cmd cmd);
        t_back_state s;
        if (!cmd.trailer) begin
            s = BK_IDLE;
        end else if (cmd.has_opt) begin
            s = BK_OPT_HDR;
        end else begin
            s = BK_TRAILER;
        end
        return s;
    endfunction

    function automatic t_back_state first_state(input t_cmd cmd);
        t_back_state s;
        if (cmd.is_header) begin
            s = BK_TYPE;
        end else begin
            s = BK_WORD;
        end
        return s;
    endfunction

endpackage

// ----- rtl/pcapng_front.sv -----
// front end: takes input transfers, packs payload bytes and queues jobs
`timescale 1ns / 1ps

module pcapng_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  pcapng_pkg::t_in_item i_item,
    input  logic               i_q_full,
    output logic               o_ready,
    output logic               o_push,
    output pcapng_pkg::t_cmd   o_cmd
);

    logic        r_in_payload;
    logic [18:0] r_bytes_left;
    logic [23:0] r_partial;
    logic [1:0]  r_lane;
    logic [31:0] r_total;
    logic [31:0] r_flags;

    logic        n_in_payload;
    logic [18:0] n_bytes_left;
    logic [23:0] n_partial;
    logic [1:0]  n_lane;
    logic [31:0] n_total;
    logic [31:0] n_flags;

    logic        w_accept;
    logic        w_start;
    logic        w_byte;
    logic        w_last;
    logic [18:0] w_cap;
    logic [31:0] w_padded;
    logic [31:0] w_total;
    logic [31:0] w_word;

    assign o_ready  = !i_q_full;
    assign w_accept = i_valid && o_ready;
    assign w_start  = w_accept && (i_item.opcode == pcapng_pkg::OP_START);
    assign w_byte   = w_accept && (i_item.opcode == pcapng_pkg::OP_BYTE) && r_in_payload;
    assign w_last   = (r_bytes_left == 19'd1);

    always_comb begin
        if ({13'd0, i_item.captured_length} > pcapng_pkg::MAX_CAPTURE) begin
            w_cap = pcapng_pkg::MAX_CAPTURE[18:0];
        end else begin
            w_cap = i_item.captured_length;
        end
        w_padded = ({13'd0, w_cap} + 32'd3) & ~32'd3;
        w_total  = pcapng_pkg::HEADER_BYTES + w_padded + pcapng_pkg::TRAILER_BYTES;
        if (i_item.packet_flags != 32'd0) begin
            w_total = w_total + pcapng_pkg::FLAGS_OPT_BYTES;
        end
    end

    // upper lanes stay zero, which gives the padding of a short last word
    assign w_word = {8'd0, r_partial} | ({24'd0, i_item.payload_byte} << {r_lane, 3'b000});

    always_comb begin
        n_in_payload = r_in_payload;
        n_bytes_left = r_bytes_left;
        n_partial    = r_partial;
        n_lane       = r_lane;
        n_total      = r_total;
        n_flags      = r_flags;
        if (w_start) begin
            n_in_payload = (w_cap != 19'd0);
            n_bytes_left = w_cap;
            n_partial    = 24'd0;
            n_lane       = 2'd0;
            n_total      = w_total;
            n_flags      = i_item.packet_flags;
        end else if (w_byte) begin
            n_in_payload = !w_last;
            n_bytes_left = r_bytes_left - 19'd1;
            if (w_last || r_lane == 2'd3) begin
                n_partial = 24'd0;
                n_lane    = 2'd0;
            end else begin
                n_partial = w_word[23:0];
                n_lane    = r_lane + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_payload <= 1'b0;
            r_bytes_left <= 19'd0;
            r_partial    <= 24'd0;
            r_lane       <= 2'd0;
            r_total      <= 32'd0;
            r_flags      <= 32'd0;
        end else begin
            r_in_payload <= n_in_payload;
            r_bytes_left <= n_bytes_left;
            r_partial    <= n_partial;
            r_lane       <= n_lane;
            r_total      <= n_total;
            r_flags      <= n_flags;
        end
    end

    assign o_push = w_start || (w_byte && (w_last || r_lane == 2'd3));

    always_comb begin
        o_cmd = '0;
        if (w_start) begin
            o_cmd.is_header = 1'b1;
            o_cmd.trailer   = (w_cap == 19'd0);
            o_cmd.has_opt   = (i_item.packet_flags != 32'd0);
            o_cmd.total     = w_total;
            o_cmd.flags     = i_item.packet_flags;
            o_cmd.ifnum     = i_item.interface_number;
            o_cmd.sec       = i_item.seconds;
            o_cmd.frac      = i_item.fraction;
            o_cmd.caplen    = w_cap;
            o_cmd.origlen   = i_item.original_length;
        end else begin
            o_cmd.is_header = 1'b0;
            o_cmd.trailer   = w_last;
            o_cmd.has_opt   = (r_flags != 32'd0);
            o_cmd.total     = r_total;
            o_cmd.flags     = r_flags;
            o_cmd.word      = w_word;
        end
    end

endmodule

// ----- rtl/pcapng_cmd_fifo.sv -----
// small job queue between front end and word sequencer
`timescale 1ns / 1ps

module pcapng_cmd_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  pcapng_pkg::t_cmd i_cmd,
    input  logic             i_pop,
    output pcapng_pkg::t_cmd o_head,
    output logic             o_full,
    output logic             o_empty
);

    pcapng_pkg::t_cmd r_mem [pcapng_pkg::CMD_DEPTH];

    logic [pcapng_pkg::CMD_PTR_W-1:0] r_wr_ptr;
    logic [pcapng_pkg::CMD_PTR_W-1:0] r_rd_ptr;
    logic [pcapng_pkg::CMD_PTR_W:0]   r_count;

    assign o_full  = (r_count == (pcapng_pkg::CMD_PTR_W+1)'(pcapng_pkg::CMD_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + (pcapng_pkg::CMD_PTR_W)'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + (pcapng_pkg::CMD_PTR_W)'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (pcapng_pkg::CMD_PTR_W+1)'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - (pcapng_pkg::CMD_PTR_W+1)'(1);
            end
        end
    end

endmodule

// ----- rtl/pcapng_back.sv -----
// back end: walks each job word by word into the output register
`timescale 1ns / 1ps

module pcapng_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [29:0]           i_cfg_data,
    input  pcapng_pkg::t_cmd      i_head,
    input  logic                  i_empty,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output pcapng_pkg::t_out_item o_item
);

    pcapng_pkg::t_back_state r_state;
    pcapng_pkg::t_back_state n_state;
    pcapng_pkg::t_back_state w_after;

    pcapng_pkg::t_cmd      r_cmd;
    logic [29:0]           r_ticks;
    logic [61:0]           r_prod;
    logic [63:0]           r_ts;
    logic                  r_valid;
    pcapng_pkg::t_out_item r_item;

    logic        w_adv;
    logic        w_done;
    logic [31:0] w_word;
    logic        w_eob;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks <= pcapng_pkg::TICKS_RESET;
        end else if (i_cfg_we) begin
            r_ticks <= i_cfg_data;
        end
    end

    // timestamp settles in r_prod, then r_ts, before a loaded job's high word is due
    always_ff @(posedge i_clk) begin
        r_prod <= r_cmd.sec * r_ticks;
        r_ts   <= {2'd0, r_prod} + {32'd0, r_cmd.frac};
    end

    assign w_adv  = (r_state != pcapng_pkg::BK_IDLE) && (!r_valid || i_ready);
    assign w_done = (r_state == pcapng_pkg::BK_IDLE)
                 || (w_adv && w_after == pcapng_pkg::BK_IDLE);
    assign o_pop  = w_done && !i_empty;

    // next state
    always_comb begin
        unique case (r_state)
            pcapng_pkg::BK_TYPE:    w_after = pcapng_pkg::BK_TOTAL;
            pcapng_pkg::BK_TOTAL:   w_after = pcapng_pkg::BK_IFNUM;
            pcapng_pkg::BK_IFNUM:   w_after = pcapng_pkg::BK_TS_HI;
            pcapng_pkg::BK_TS_HI:   w_after = pcapng_pkg::BK_TS_LO;
            pcapng_pkg::BK_TS_LO:   w_after = pcapng_pkg::BK_CAPLEN;
            pcapng_pkg::BK_CAPLEN:  w_after = pcapng_pkg::BK_ORIGLEN;
            pcapng_pkg::BK_ORIGLEN: w_after = pcapng_pkg::tail_state(r_cmd);
            pcapng_pkg::BK_WORD:    w_after = pcapng_pkg::tail_state(r_cmd);
            pcapng_pkg::BK_OPT_HDR: w_after = pcapng_pkg::BK_OPT_VAL;
            pcapng_pkg::BK_OPT_VAL: w_after = pcapng_pkg::BK_OPT_END;
            pcapng_pkg::BK_OPT_END: w_after = pcapng_pkg::BK_TRAILER;
            default:                w_after = pcapng_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        priority if (o_pop) begin
            n_state = pcapng_pkg::first_state(i_head);
        end else if (w_done) begin
            n_state = pcapng_pkg::BK_IDLE;
        end else if (w_adv) begin
            n_state = w_after;
        end else begin
            n_state = r_state;
        end
    end

    // word of the current step
    always_comb begin
        w_eob = 1'b0;
        unique case (r_state)
            pcapng_pkg::BK_TYPE:    w_word = pcapng_pkg::BLOCK_TYPE_EPB;
            pcapng_pkg::BK_TOTAL:   w_word = r_cmd.total;
            pcapng_pkg::BK_IFNUM:   w_word = r_cmd.ifnum;
            pcapng_pkg::BK_TS_HI:   w_word = r_ts[63:32];
            pcapng_pkg::BK_TS_LO:   w_word = r_ts[31:0];
            pcapng_pkg::BK_CAPLEN:  w_word = {13'd0, r_cmd.caplen};
            pcapng_pkg::BK_ORIGLEN: w_word = r_cmd.origlen;
            pcapng_pkg::BK_WORD:    w_word = r_cmd.word;
            pcapng_pkg::BK_OPT_HDR: w_word = pcapng_pkg::FLAGS_OPT_HEADER;
            pcapng_pkg::BK_OPT_VAL: w_word = r_cmd.flags;
            pcapng_pkg::BK_OPT_END: w_word = pcapng_pkg::END_OF_OPTIONS;
            pcapng_pkg::BK_TRAILER: begin
                w_word = r_cmd.total;
                w_eob  = 1'b1;
            end
            default:                w_word = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pcapng_pkg::BK_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_adv) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_head;
        end
        if (w_adv) begin
            r_item.out_word     <= w_word;
            r_item.end_of_block <= w_eob;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ----- rtl/pcapng_packet_block_framer.sv -----
// top level of the enhanced packet block framer
//
//  channel  direction  handshake                   payload
//  in       input      i_in_valid / o_in_ready     i_in  (t_in_item)
//  out      output     o_out_valid / i_out_ready   o_out (t_out_item)
//  cfg      input      i_cfg_we                    i_cfg_data (ticks per second)
//
// one input transfer per cycle while the job queue has room; a start item
// becomes 7 to 11 output words, a payload byte 0 to 5, one word per cycle
// from the sequencer unless the output stalls; a job passes the queue, r_cmd
// and output register, the timestamp multiply running under earlier header words
// synchronous active-low reset empties the queue and the output register
// header bursts or a stalled output fill the queue, then o_in_ready drops
`timescale 1ns / 1ps

module pcapng_packet_block_framer (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  pcapng_pkg::t_in_item  i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output pcapng_pkg::t_out_item o_out,
    input  logic                  i_cfg_we,
    input  logic [29:0]           i_cfg_data
);

    pcapng_pkg::t_q_stat w_q;
    pcapng_pkg::t_cmd    w_push_cmd;
    pcapng_pkg::t_cmd    w_head;

    pcapng_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .i_item   (i_in),
        .i_q_full (w_q.full),
        .o_ready  (o_in_ready),
        .o_push   (w_q.push),
        .o_cmd    (w_push_cmd)
    );

    pcapng_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q.push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_q.pop),
        .o_head  (w_head),
        .o_full  (w_q.full),
        .o_empty (w_q.empty)
    );

    pcapng_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_head     (w_head),
        .i_empty    (w_q.empty),
        .o_pop      (w_q.pop),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_item     (o_out)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q.push |-> !w_q.full)
        else $error("job pushed into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q.pop |-> !w_q.empty)
        else $error("job popped from an empty queue");

    a_trailer_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.end_of_block) |-> (o_out.out_word[1:0] == 2'b00))
        else $error("block total length not a multiple of four");

endmodule
